[src/fqt_pkg.sv]
package fqt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int KEY_W       = 64;
    localparam int CNT_W       = 8;
    localparam int DL_W        = 48;
    localparam int TIME_W      = 32;
    localparam int BASE_W      = 16;
    localparam int LIM_W       = 5;
    localparam int SH_W        = 5;
    localparam int MAX_LIST    = 16;

    localparam logic [CNT_W-1:0]  CNT_MAX       = '1;
    localparam logic [SH_W-1:0]   SHIFT_MAX     = '1;
    localparam logic [BASE_W-1:0] BASE_RESET    = BASE_W'(60);
    localparam logic [CNT_W-1:0]  THRESH_RESET  = CNT_W'(3);

    localparam logic [1:0] CMD_RECORD = 2'd0;
    localparam logic [1:0] CMD_QUERY  = 2'd1;
    localparam logic [1:0] CMD_DUMP   = 2'd2;

    localparam logic CFG_BASE_COOLDOWN = 1'b0;
    localparam logic CFG_THRESHOLD     = 1'b1;

endpackage

[src/failure_quarantine_table.sv]
// Failure quarantine table: tracks up to 16 failing ids with a consecutive
// failure count and an exponential backoff deadline.
// Input channel (cmd_valid / cmd_stall) carries one command item: record,
// query or dump. Result channel (res_valid / res_stall) carries result items.
// Record gives no result; query gives exactly one unless its id is zero;
// dump gives one item per listed entry (at least one), with is_last set on
// the final one. Each item is handled by a sequencer that walks the table
// one slot per cycle through a single 64-bit key compare. A record that
// counts a failure scans the table, then takes the deadline shift in S_CALC
// and the add and table write in S_WRITE before the next item is taken.
// cmd_stall is low only while the sequencer is idle, and the next item may
// be taken while the last result still waits in the output register.
// When the receiver stalls, the result register holds its item and a dump
// scan pauses until the register frees up.
// Reset (rst_n low) empties the table at once through per-slot valid bits and
// loads base_cooldown 60 and failure_threshold 3. Configuration writes are
// taken at any edge with cfg_we high.
module failure_quarantine_table (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic                            cfg_addr,
    input  logic [fqt_pkg::BASE_W-1:0]      cfg_wdata,
    input  logic                            cmd_valid,
    output logic                            cmd_stall,
    input  logic [1:0]                      command,
    input  logic [fqt_pkg::KEY_W-1:0]       entry_key,
    input  logic                            run_succeeded,
    input  logic [fqt_pkg::TIME_W-1:0]      current_time,
    input  logic [fqt_pkg::LIM_W-1:0]       dump_limit,
    output logic                            res_valid,
    input  logic                            res_stall,
    output logic                            entry_valid,
    output logic                            quarantined,
    output logic [fqt_pkg::KEY_W-1:0]       id_out,
    output logic [fqt_pkg::CNT_W-1:0]       failure_count,
    output logic                            is_last
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_CALC   = 5'b00100,
        S_WRITE  = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    localparam logic [fqt_pkg::IDX_W-1:0] IDX_LAST = fqt_pkg::IDX_W'(fqt_pkg::TABLE_DEPTH - 1);

    // Table storage.
    logic [fqt_pkg::TABLE_DEPTH-1:0] valid_reg;
    logic [fqt_pkg::KEY_W-1:0]       ids_reg   [fqt_pkg::TABLE_DEPTH];
    logic [fqt_pkg::CNT_W-1:0]       cnts_reg  [fqt_pkg::TABLE_DEPTH];
    logic [fqt_pkg::DL_W-1:0]        dls_reg   [fqt_pkg::TABLE_DEPTH];

    logic [fqt_pkg::BASE_W-1:0] base_reg;
    logic [fqt_pkg::CNT_W-1:0]  thresh_reg;

    state_t                      state_reg, state_next;
    logic [1:0]                  cmd_reg, cmd_next;
    logic [fqt_pkg::KEY_W-1:0]   key_reg, key_next;
    logic                        ok_reg, ok_next;
    logic [fqt_pkg::TIME_W-1:0]  now_reg, now_next;
    logic [fqt_pkg::LIM_W-1:0]   lim_reg, lim_next;
    logic [fqt_pkg::LIM_W-1:0]   n_reg, n_next;
    logic [fqt_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic                        empty_found_reg, empty_found_next;
    logic [fqt_pkg::IDX_W-1:0]   empty_slot_reg, empty_slot_next;
    logic [fqt_pkg::IDX_W-1:0]   slot_reg, slot_next;
    logic [fqt_pkg::CNT_W-1:0]   base_cnt_reg, base_cnt_next;
    logic                        insert_reg, insert_next;
    logic [fqt_pkg::CNT_W-1:0]   new_cnt_reg, new_cnt_next;
    logic                        apply_reg, apply_next;
    logic [fqt_pkg::DL_W-1:0]    shifted_reg, shifted_next;

    logic                        held_valid_reg, held_valid_next;
    logic                        held_quar_reg, held_quar_next;
    logic [fqt_pkg::KEY_W-1:0]   held_id_reg, held_id_next;
    logic [fqt_pkg::CNT_W-1:0]   held_cnt_reg, held_cnt_next;

    logic                        res_valid_reg, res_valid_next;
    logic                        res_entry_reg, res_entry_next;
    logic                        res_quar_reg, res_quar_next;
    logic [fqt_pkg::KEY_W-1:0]   res_id_reg, res_id_next;
    logic [fqt_pkg::CNT_W-1:0]   res_cnt_reg, res_cnt_next;
    logic                        res_last_reg, res_last_next;

    logic                        tab_clr;
    logic                        tab_wr;

    // Shared slot read path and compare unit.
    logic                        rd_valid;
    logic [fqt_pkg::CNT_W-1:0]   rd_cnt;
    logic [fqt_pkg::DL_W-1:0]    rd_dl;
    logic                        hit;
    logic                        last_slot;
    logic                        qual;
    logic                        out_free;
    logic [fqt_pkg::LIM_W-1:0]   n_inc;
    logic [fqt_pkg::CNT_W-1:0]   cnt_inc;
    logic [fqt_pkg::CNT_W-1:0]   sh_full;
    logic [fqt_pkg::SH_W-1:0]    sh_amt;
    logic [fqt_pkg::DL_W-1:0]    dl_sum;

    assign rd_valid  = valid_reg[idx_reg];
    assign rd_cnt    = cnts_reg[idx_reg];
    assign rd_dl     = dls_reg[idx_reg];
    assign hit       = rd_valid && (ids_reg[idx_reg] == key_reg);
    assign last_slot = (idx_reg == IDX_LAST);
    assign qual      = rd_valid && (rd_cnt != '0);
    assign out_free  = !res_valid_reg || !res_stall;
    assign n_inc     = n_reg + fqt_pkg::LIM_W'(1);
    assign cnt_inc   = (base_cnt_reg == fqt_pkg::CNT_MAX) ?
                       fqt_pkg::CNT_MAX : base_cnt_reg + fqt_pkg::CNT_W'(1);
    assign sh_full   = cnt_inc - thresh_reg;
    assign sh_amt    = (sh_full > fqt_pkg::CNT_W'(fqt_pkg::SHIFT_MAX)) ?
                       fqt_pkg::SHIFT_MAX : sh_full[fqt_pkg::SH_W-1:0];
    assign dl_sum    = shifted_reg + fqt_pkg::DL_W'(now_reg);

    assign cmd_stall     = (state_reg != S_IDLE);
    assign res_valid     = res_valid_reg;
    assign entry_valid   = res_entry_reg;
    assign quarantined   = res_quar_reg;
    assign id_out        = res_id_reg;
    assign failure_count = res_cnt_reg;
    assign is_last       = res_last_reg;

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        key_next         = key_reg;
        ok_next          = ok_reg;
        now_next         = now_reg;
        lim_next         = lim_reg;
        n_next           = n_reg;
        idx_next         = idx_reg;
        empty_found_next = empty_found_reg;
        empty_slot_next  = empty_slot_reg;
        slot_next        = slot_reg;
        base_cnt_next    = base_cnt_reg;
        insert_next      = insert_reg;
        new_cnt_next     = new_cnt_reg;
        apply_next       = apply_reg;
        shifted_next     = shifted_reg;
        held_valid_next  = held_valid_reg;
        held_quar_next   = held_quar_reg;
        held_id_next     = held_id_reg;
        held_cnt_next    = held_cnt_reg;
        res_valid_next   = res_valid_reg && res_stall;
        res_entry_next   = res_entry_reg;
        res_quar_next    = res_quar_reg;
        res_id_next      = res_id_reg;
        res_cnt_next     = res_cnt_reg;
        res_last_next    = res_last_reg;
        tab_clr          = 1'b0;
        tab_wr           = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next         = command;
                    key_next         = entry_key;
                    ok_next          = run_succeeded;
                    now_next         = current_time;
                    lim_next         = (dump_limit > fqt_pkg::LIM_W'(fqt_pkg::MAX_LIST)) ?
                                       fqt_pkg::LIM_W'(fqt_pkg::MAX_LIST) : dump_limit;
                    n_next           = '0;
                    idx_next         = '0;
                    empty_found_next = 1'b0;
                    held_valid_next  = 1'b0;
                    held_quar_next   = 1'b0;
                    held_cnt_next    = '0;
                    held_id_next     = (command == fqt_pkg::CMD_QUERY) ? entry_key : '0;
                    if (command == fqt_pkg::CMD_DUMP)
                    begin
                        state_next = (dump_limit == '0) ? S_FINISH : S_SCAN;
                    end
                    else if ((command == fqt_pkg::CMD_RECORD || command == fqt_pkg::CMD_QUERY)
                             && entry_key != '0)
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                unique case (cmd_reg)
                    fqt_pkg::CMD_RECORD:
                    begin
                        if (hit)
                        begin
                            if (ok_reg)
                            begin
                                tab_clr    = 1'b1;
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                slot_next     = idx_reg;
                                base_cnt_next = rd_cnt;
                                insert_next   = 1'b0;
                                state_next    = S_CALC;
                            end
                        end
                        else if (last_slot)
                        begin
                            if (!ok_reg && (empty_found_reg || !rd_valid))
                            begin
                                slot_next     = empty_found_reg ? empty_slot_reg : idx_reg;
                                base_cnt_next = '0;
                                insert_next   = 1'b1;
                                state_next    = S_CALC;
                            end
                            else
                            begin
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            if (!rd_valid && !empty_found_reg)
                            begin
                                empty_found_next = 1'b1;
                                empty_slot_next  = idx_reg;
                            end
                            idx_next = idx_reg + fqt_pkg::IDX_W'(1);
                        end
                    end

                    fqt_pkg::CMD_QUERY:
                    begin
                        if (hit)
                        begin
                            held_valid_next = 1'b1;
                            held_quar_next  = (rd_dl > fqt_pkg::DL_W'(now_reg));
                            held_cnt_next   = rd_cnt;
                            state_next      = S_FINISH;
                        end
                        else if (last_slot)
                        begin
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            idx_next = idx_reg + fqt_pkg::IDX_W'(1);
                        end
                    end

                    default:
                    begin
                        // A listed entry moves out only once the next one is found,
                        // so that the final one can carry is_last.
                        if (!(qual && held_valid_reg && !out_free))
                        begin
                            if (qual)
                            begin
                                if (held_valid_reg)
                                begin
                                    res_valid_next = 1'b1;
                                    res_entry_next = 1'b1;
                                    res_quar_next  = 1'b0;
                                    res_id_next    = held_id_reg;
                                    res_cnt_next   = held_cnt_reg;
                                    res_last_next  = 1'b0;
                                end
                                held_valid_next = 1'b1;
                                held_id_next    = ids_reg[idx_reg];
                                held_cnt_next   = rd_cnt;
                                n_next          = n_inc;
                            end
                            if (last_slot || (qual && n_inc == lim_reg))
                            begin
                                state_next = S_FINISH;
                            end
                            else
                            begin
                                idx_next = idx_reg + fqt_pkg::IDX_W'(1);
                            end
                        end
                    end
                endcase
            end

            S_CALC:
            begin
                new_cnt_next = cnt_inc;
                apply_next   = (cnt_inc >= thresh_reg);
                shifted_next = fqt_pkg::DL_W'(base_reg) << sh_amt;
                state_next   = S_WRITE;
            end

            S_WRITE:
            begin
                tab_wr     = 1'b1;
                state_next = S_IDLE;
            end

            S_FINISH:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_entry_next = held_valid_reg;
                    res_quar_next  = held_quar_reg;
                    res_id_next    = held_id_reg;
                    res_cnt_next   = held_cnt_reg;
                    res_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            base_reg       <= fqt_pkg::BASE_RESET;
            thresh_reg     <= fqt_pkg::THRESH_RESET;
            res_valid_reg  <= 1'b0;
            held_valid_reg <= 1'b0;
            n_reg          <= '0;
            lim_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            res_valid_reg  <= res_valid_next;
            held_valid_reg <= held_valid_next;
            n_reg          <= n_next;
            lim_reg        <= lim_next;
            if (tab_wr)
            begin
                valid_reg[slot_reg] <= 1'b1;
            end
            if (cfg_we)
            begin
                if (cfg_addr == fqt_pkg::CFG_BASE_COOLDOWN)
                begin
                    base_reg <= cfg_wdata;
                end
                else
                begin
                    thresh_reg <= cfg_wdata[fqt_pkg::CNT_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        key_reg         <= key_next;
        ok_reg          <= ok_next;
        now_reg         <= now_next;
        idx_reg         <= idx_next;
        empty_found_reg <= empty_found_next;
        empty_slot_reg  <= empty_slot_next;
        slot_reg        <= slot_next;
        base_cnt_reg    <= base_cnt_next;
        insert_reg      <= insert_next;
        new_cnt_reg     <= new_cnt_next;
        apply_reg       <= apply_next;
        shifted_reg     <= shifted_next;
        held_quar_reg   <= held_quar_next;
        held_id_reg     <= held_id_next;
        held_cnt_reg    <= held_cnt_next;
        res_entry_reg   <= res_entry_next;
        res_quar_reg    <= res_quar_next;
        res_id_reg      <= res_id_next;
        res_cnt_reg     <= res_cnt_next;
        res_last_reg    <= res_last_next;

        if (tab_clr)
        begin
            cnts_reg[idx_reg] <= '0;
            dls_reg[idx_reg]  <= '0;
        end
        if (tab_wr)
        begin
            ids_reg[slot_reg]  <= key_reg;
            cnts_reg[slot_reg] <= new_cnt_reg;
            if (apply_reg)
            begin
                dls_reg[slot_reg] <= dl_sum;
            end
            else if (insert_reg)
            begin
                dls_reg[slot_reg] <= '0;
            end
        end
    end

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state is not one-hot");

    a_dump_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && cmd_reg == fqt_pkg::CMD_DUMP) |-> (n_reg < lim_reg))
        else $error("dump scan continued past its limit");

    a_valid_only_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_WRITE) |=> $stable(valid_reg))
        else $error("slot valid bits changed outside a table write");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall && command == fqt_pkg::CMD_QUERY && entry_key != '0)
        |=> (state_reg == S_SCAN))
        else $error("accepted query did not start a table scan");

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && res_valid_reg && res_stall) |=> (state_reg == S_FINISH))
        else $error("final result left while the result register was full");

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

    localparam int    HALF_PERIOD  = 2;
    localparam int    DRAIN_CYCLES = 40;
    localparam int    LONG_HOLD    = 120;
    localparam int    POOL_N       = 20;
    localparam int    NUM_DIRECTED = 22;
    localparam int    SAT_RECORDS  = 40;
    localparam int    RUN_ITEMS    = 20;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [fqt_pkg::KEY_W-1:0] KEY_TOP = '1;
    localparam logic [fqt_pkg::KEY_W-1:0] KEY_MSB = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic                      found;
        logic                      quar;
        logic [fqt_pkg::KEY_W-1:0] id;
        logic [fqt_pkg::CNT_W-1:0] cnt;
        logic                      last;
    } reply_t;

    typedef struct packed {
        logic [1:0]                 cmd;
        logic [fqt_pkg::KEY_W-1:0]  key;
        logic                       ok;
        logic [fqt_pkg::TIME_W-1:0] now;
        logic [fqt_pkg::LIM_W-1:0]  lim;
        logic                       typed;
        reply_t                     want;
    } cmd_row_t;

    localparam reply_t NO_REPLY   = '0;
    localparam reply_t EMPTY_DUMP = '{1'b0, 1'b0, 64'd0, 8'd0, 1'b1};

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_we;
    logic                       cfg_addr;
    logic [fqt_pkg::BASE_W-1:0] cfg_wdata;
    logic                       cmd_valid;
    logic                       cmd_stall;
    logic [1:0]                 command;
    logic [fqt_pkg::KEY_W-1:0]  entry_key;
    logic                       run_succeeded;
    logic [fqt_pkg::TIME_W-1:0] current_time;
    logic [fqt_pkg::LIM_W-1:0]  dump_limit;
    logic                       res_valid;
    logic                       res_stall;
    logic                       entry_valid;
    logic                       quarantined;
    logic [fqt_pkg::KEY_W-1:0]  id_out;
    logic [fqt_pkg::CNT_W-1:0]  failure_count;
    logic                       is_last;

    // Shadow copy of the table and its settings.
    logic [fqt_pkg::KEY_W-1:0]  tbl_id       [fqt_pkg::TABLE_DEPTH];
    logic [fqt_pkg::CNT_W-1:0]  tbl_cnt      [fqt_pkg::TABLE_DEPTH];
    logic [fqt_pkg::DL_W-1:0]   tbl_deadline [fqt_pkg::TABLE_DEPTH];
    logic [fqt_pkg::BASE_W-1:0] cool_base;
    logic [fqt_pkg::CNT_W-1:0]  fail_thresh;

    reply_t                     replies_due [$];
    int                         mismatches = 0;
    logic [fqt_pkg::KEY_W-1:0]  key_pool [POOL_N];
    logic [fqt_pkg::TIME_W-1:0] sim_now = '0;
    bit                         no_gaps = 1'b0;
    bit                         hold_req = 1'b0;

    cmd_row_t dir_rows [NUM_DIRECTED] = '{
        '{fqt_pkg::CMD_DUMP,   64'd0,   1'b0, 32'd0,         5'd16, 1'b1, EMPTY_DUMP},
        '{fqt_pkg::CMD_QUERY,  64'd5,   1'b0, 32'd0,         5'd0,  1'b1,
          '{1'b0, 1'b0, 64'd5, 8'd0, 1'b1}},
        '{fqt_pkg::CMD_RECORD, 64'd0,   1'b0, 32'd10,        5'd0,  1'b0, NO_REPLY},
        '{fqt_pkg::CMD_QUERY,  64'd0,   1'b1, 32'd10,        5'd0,  1'b0, NO_REPLY},
        '{CMD_UNUSED,          64'd9,   1'b0, 32'd10,        5'd16, 1'b0, NO_REPLY},
        '{fqt_pkg::CMD_RECORD, 64'd7,   1'b1, 32'd20,        5'd0,  1'b0, NO_REPLY},
        '{fqt_pkg::CMD_QUERY,  64'd7,   1'b0, 32'd20,        5'd0,  1'b1,
          '{1'b0, 1'b0, 64'd7, 8'd0, 1'b1}},
        '{fqt_pkg::CMD_RECORD, KEY_TOP, 1'b0, 32'd0,         5'd0,  1'b0, NO_REPLY},
        '{fqt_pkg::CMD_RECORD, KEY_TOP, 1'b0, 32'd100,       5'd0,  1'b0, NO_REPLY},
        '{fqt_pkg::CMD_QUERY,  KEY_TOP, 1'b0, 32'd100,       5'd0,  1'b0, NO_REPLY},
        '{fqt_pkg::CMD_RECORD, KEY_TOP, 1'b0, 32'hFFFF_FFFF, 5'd0,  1'b0, NO_REPLY},
        '{fqt_pkg::CMD_QUERY,  KEY_TOP, 1'b0, 32'hFFFF_FFFF, 5'd0,  1'b0, NO_REPLY},
        '{fqt_pkg::CMD_RECORD, 64'd1,   1'b0, 32'd0,         5'd0,  1'b0, NO_REPLY},
        '{fqt_pkg::CMD_DUMP,   KEY_TOP, 1'b1, 32'd0,         5'd0,  1'b1, EMPTY_DUMP},
        '{fqt_pkg::CMD_DUMP,   64'd0,   1'b0, 32'd0,         5'd1,  1'b0, NO_REPLY},
        '{fqt_pkg::CMD_DUMP,   64'd0,   1'b0, 32'd0,         5'd16, 1'b0, NO_REPLY},
        '{fqt_pkg::CMD_RECORD, KEY_TOP, 1'b1, 32'd5,         5'd0,  1'b0, NO_REPLY},
        '{fqt_pkg::CMD_QUERY,  KEY_TOP, 1'b0, 32'd0,         5'd0,  1'b0, NO_REPLY},
        '{fqt_pkg::CMD_DUMP,   64'd0,   1'b0, 32'd0,         5'd16, 1'b0, NO_REPLY},
        '{fqt_pkg::CMD_RECORD, KEY_MSB, 1'b0, 32'h8000_0000, 5'd0,  1'b0, NO_REPLY},
        '{fqt_pkg::CMD_QUERY,  KEY_MSB, 1'b0, 32'h7FFF_FFFF, 5'd0,  1'b0, NO_REPLY},
        '{fqt_pkg::CMD_DUMP,   64'd0,   1'b0, 32'd0,         5'd15, 1'b0, NO_REPLY}
    };

    failure_quarantine_table u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .cmd_valid     (cmd_valid),
        .cmd_stall     (cmd_stall),
        .command       (command),
        .entry_key     (entry_key),
        .run_succeeded (run_succeeded),
        .current_time  (current_time),
        .dump_limit    (dump_limit),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .entry_valid   (entry_valid),
        .quarantined   (quarantined),
        .id_out        (id_out),
        .failure_count (failure_count),
        .is_last       (is_last)
    );

    always #(HALF_PERIOD) clk = ~clk;

    task automatic flag_mismatch(input string what, input logic [fqt_pkg::KEY_W-1:0] got,
                                 input logic [fqt_pkg::KEY_W-1:0] want);
        $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic check_field(input string what, input logic [fqt_pkg::KEY_W-1:0] got,
                               input logic [fqt_pkg::KEY_W-1:0] want);
        if (got !== want)
            flag_mismatch(what, got, want);
    endtask

    task automatic count_failure(input int s, input logic [fqt_pkg::TIME_W-1:0] now);
        int sh;
        if (tbl_cnt[s] != fqt_pkg::CNT_MAX)
            tbl_cnt[s]++;
        if (tbl_cnt[s] >= fail_thresh)
        begin
            sh = int'(tbl_cnt[s]) - int'(fail_thresh);
            if (sh > 31)
                sh = 31;
            tbl_deadline[s] = fqt_pkg::DL_W'(64'(now) + (64'(cool_base) << sh));
        end
    endtask

    // Applies one accepted command to the shadow table and returns its replies.
    task automatic quarantine_step(input cmd_row_t row, output reply_t out [$]);
        int hit;
        int empty;
        int lim_n;
        out = {};
        hit = -1;
        empty = -1;
        for (int i = 0; i < fqt_pkg::TABLE_DEPTH; i++)
        begin
            if (tbl_id[i] == row.key && hit < 0)
                hit = i;
            if (tbl_id[i] == '0 && empty < 0)
                empty = i;
        end
        case (row.cmd)
            fqt_pkg::CMD_RECORD:
            begin
                if (row.key != '0)
                begin
                    if (hit >= 0 && row.ok)
                    begin
                        tbl_cnt[hit] = '0;
                        tbl_deadline[hit] = '0;
                    end
                    else if (hit >= 0)
                        count_failure(hit, row.now);
                    else if (!row.ok && empty >= 0)
                    begin
                        tbl_id[empty] = row.key;
                        tbl_cnt[empty] = '0;
                        tbl_deadline[empty] = '0;
                        count_failure(empty, row.now);
                    end
                end
            end
            fqt_pkg::CMD_QUERY:
            begin
                if (row.key != '0 && hit >= 0)
                    out.push_back(reply_t'{1'b1,
                                           tbl_deadline[hit] > fqt_pkg::DL_W'(row.now),
                                           row.key, tbl_cnt[hit], 1'b1});
                else if (row.key != '0)
                    out.push_back(reply_t'{1'b0, 1'b0, row.key, 8'd0, 1'b1});
            end
            fqt_pkg::CMD_DUMP:
            begin
                lim_n = (row.lim > fqt_pkg::MAX_LIST) ? fqt_pkg::MAX_LIST : int'(row.lim);
                for (int i = 0; i < fqt_pkg::TABLE_DEPTH; i++)
                    if (out.size() < lim_n && tbl_id[i] != '0 && tbl_cnt[i] != '0)
                        out.push_back(reply_t'{1'b1, 1'b0, tbl_id[i], tbl_cnt[i], 1'b0});
                if (out.size() == 0)
                    out.push_back(EMPTY_DUMP);
                else
                    out[out.size() - 1].last = 1'b1;
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Called at a rising edge; returns at the edge where the item is taken.
    task automatic offer_item(input cmd_row_t row);
        int gap;
        reply_t due [$];
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid     <= 1'b1;
        command       <= row.cmd;
        entry_key     <= row.key;
        run_succeeded <= row.ok;
        current_time  <= row.now;
        dump_limit    <= row.lim;
        do
            @(posedge clk);
        while (cmd_stall);
        quarantine_step(row, due);
        if (row.typed)
            replies_due.push_back(row.want);
        else
            foreach (due[k])
                replies_due.push_back(due[k]);
    endtask

    task automatic await_replies();
        while (replies_due.size() != 0)
            @(posedge clk);
    endtask

    // Records give no reply, so allow the sequencer time to finish the last one.
    task automatic drain();
        cmd_valid <= 1'b0;
        await_replies();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [fqt_pkg::BASE_W-1:0] base,
                              input logic [fqt_pkg::CNT_W-1:0] thr);
        cfg_we    <= 1'b1;
        cfg_addr  <= fqt_pkg::CFG_BASE_COOLDOWN;
        cfg_wdata <= base;
        @(posedge clk);
        cfg_addr  <= fqt_pkg::CFG_THRESHOLD;
        cfg_wdata <= {8'($urandom), thr};
        @(posedge clk);
        cfg_we    <= 1'b0;
        cool_base   = base;
        fail_thresh = thr;
    endtask

    function automatic cmd_row_t random_item();
        cmd_row_t row;
        int pick;
        row = '0;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 4)
            sim_now = $urandom;
        else
            sim_now += $urandom_range(0, 40);
        row.now = sim_now;
        row.key = key_pool[$urandom_range(0, POOL_N - 1)];
        row.ok  = ($urandom_range(0, 3) == 0);
        row.lim = fqt_pkg::LIM_W'($urandom_range(0, fqt_pkg::MAX_LIST));
        if (pick < 52)
            row.cmd = fqt_pkg::CMD_RECORD;
        else if (pick < 77)
        begin
            row.cmd = fqt_pkg::CMD_QUERY;
            if ($urandom_range(0, 9) == 0)
                row.key = {$urandom, $urandom};
        end
        else if (pick < 90)
            row.cmd = fqt_pkg::CMD_DUMP;
        else if (pick < 95)
        begin
            row.cmd = $urandom_range(0, 1) ? fqt_pkg::CMD_QUERY : fqt_pkg::CMD_RECORD;
            row.key = '0;
        end
        else
            row.cmd = CMD_UNUSED;
        return row;
    endfunction

    task automatic random_run(input int count, input int hold_at, input int pause_at);
        cmd_row_t row;
        bit saved;
        no_gaps = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < count; i++)
        begin
            if (i == hold_at)
            begin
                // Sink holds off while dumps keep coming, so the block backs up.
                hold_req = 1'b1;
                saved = no_gaps;
                no_gaps = 1'b1;
                repeat (6)
                begin
                    row = '0;
                    row.cmd = fqt_pkg::CMD_DUMP;
                    row.lim = fqt_pkg::LIM_W'(fqt_pkg::MAX_LIST);
                    offer_item(row);
                end
                no_gaps = saved;
            end
            if (i == pause_at)
            begin
                cmd_valid <= 1'b0;
                @(posedge clk);
                await_replies();
            end
            offer_item(random_item());
        end
    endtask

    always @(posedge clk)
    begin : result_check
        reply_t w;
        if (rst_n && res_valid && !res_stall)
        begin
            if (replies_due.size() == 0)
                flag_mismatch("item with no reply due, id_out", id_out, '0);
            else
            begin
                w = replies_due.pop_front();
                check_field("entry_valid", fqt_pkg::KEY_W'(entry_valid),
                            fqt_pkg::KEY_W'(w.found));
                check_field("quarantined", fqt_pkg::KEY_W'(quarantined),
                            fqt_pkg::KEY_W'(w.quar));
                check_field("id_out", id_out, w.id);
                check_field("failure_count", fqt_pkg::KEY_W'(failure_count),
                            fqt_pkg::KEY_W'(w.cnt));
                check_field("is_last", fqt_pkg::KEY_W'(is_last), fqt_pkg::KEY_W'(w.last));
            end
        end
    end

    initial
    begin : sink
        int left;
        int r;
        bit stalling;
        left = 0;
        stalling = 1'b0;
        res_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                res_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                left = 0;
            end
            if (left == 0)
            begin
                r = $urandom_range(0, 99);
                if (r < 45)
                begin
                    stalling = 1'b0;
                    left = $urandom_range(1, 8);
                end
                else if (r < 55)
                begin
                    stalling = 1'b0;
                    left = $urandom_range(20, 60);
                end
                else if (r < 93)
                begin
                    stalling = 1'b1;
                    left = $urandom_range(1, 3);
                end
                else
                begin
                    stalling = 1'b1;
                    left = $urandom_range(10, 40);
                end
            end
            res_stall <= stalling;
            left--;
        end
    end

    initial
    begin : stimulus
        cmd_row_t row;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = 1'b0;
        cfg_wdata     = '0;
        cmd_valid     = 1'b0;
        command       = fqt_pkg::CMD_RECORD;
        entry_key     = '0;
        run_succeeded = 1'b0;
        current_time  = '0;
        dump_limit    = '0;
        cool_base     = fqt_pkg::BASE_RESET;
        fail_thresh   = fqt_pkg::THRESH_RESET;
        for (int i = 0; i < fqt_pkg::TABLE_DEPTH; i++)
        begin
            tbl_id[i]       = '0;
            tbl_cnt[i]      = '0;
            tbl_deadline[i] = '0;
        end
        key_pool[0] = KEY_TOP;
        key_pool[1] = 64'd1;
        key_pool[2] = KEY_MSB;
        for (int i = 3; i < POOL_N; i++)
        begin
            key_pool[i] = {$urandom, $urandom};
            if (key_pool[i] == '0)
                key_pool[i] = 64'd2;
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
            offer_item(dir_rows[i]);
        drain();

        set_config(16'd1, 8'd1);
        random_run(RUN_ITEMS, -1, -1);
        drain();

        // Drive one id far past the shift cap.
        set_config(16'hFFFF, 8'd1);
        for (int i = 0; i < SAT_RECORDS; i++)
        begin
            row = '0;
            row.cmd = fqt_pkg::CMD_RECORD;
            row.key = KEY_TOP;
            row.now = $urandom;
            offer_item(row);
        end
        row = '0;
        row.cmd = fqt_pkg::CMD_QUERY;
        row.key = KEY_TOP;
        row.now = '1;
        offer_item(row);
        drain();

        set_config(16'hFFFF, 8'hFF);
        random_run(RUN_ITEMS, 8, -1);
        drain();

        set_config(fqt_pkg::BASE_W'($urandom_range(1, 65535)),
                   fqt_pkg::CNT_W'($urandom_range(1, 8)));
        random_run(RUN_ITEMS, -1, 10);
        drain();

        set_config(16'd2, 8'd2);
        random_run(RUN_ITEMS, 12, 5);
        drain();

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin : watchdog
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
